/* design/stack_machine_execute_unit_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef STACK_MACHINE_EXECUTE_UNIT_TOP_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SMEU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SMEU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/smeu_pkg.sv */
`default_nettype none
package smeu_pkg;
  localparam logic [4:0] F_DIVMOD = 5'd0;
  localparam logic [4:0] F_JUMP = 5'd1;
  localparam logic [4:0] F_PUSHLN = 5'd2;
  localparam logic [4:0] F_SUB = 5'd3;
  localparam logic [4:0] F_OUT = 5'd4;
  localparam logic [4:0] F_IN = 5'd5;
  localparam logic [4:0] F_ROLL = 5'd6;
  localparam logic [4:0] F_PUSH = 5'd7;
  localparam logic [4:0] F_NEWLINE = 5'd8;
  localparam logic [4:0] F_CBREL = 5'd9;
  localparam logic [4:0] F_CMPSKIP = 5'd10;
  localparam logic [4:0] F_ADDLN = 5'd11;
  localparam logic [4:0] F_BREL = 5'd12;
  localparam logic [4:0] F_ROLLI = 5'd13;
  localparam logic [4:0] F_CBABS = 5'd14;
  localparam logic [4:0] F_SUBI = 5'd15;
  localparam logic [4:0] F_DUP = 5'd16;
  localparam logic [4:0] F_DROP = 5'd17;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER = 3'd2;
  localparam logic [2:0] ST_BADLINE = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;
  localparam logic [2:0] ST_DEPTH = 3'd5;

  // Request to the divider and its answer.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

/* design/smeu_ram.sv */
`default_nettype none
module smeu_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* design/smeu_div.sv */
`default_nettype none
// Signed radix-2 restoring divider, one quotient bit per cycle.
module smeu_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire smeu_pkg::div_req_t req_i,
  output smeu_pkg::div_rsp_t      rsp_o
);
  logic [31:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic        qn_q, qn_d, rn_q, rn_d;
  logic [32:0] trial;
  logic [31:0] ua, ub;

  always_comb begin
    ua = req_i.dividend[31] ? 32'(-req_i.dividend) : req_i.dividend;
    ub = req_i.divisor[31] ? 32'(-req_i.divisor) : req_i.divisor;
    q_d = q_q;
    r_d = r_q;
    d_d = d_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    qn_d = qn_q;
    rn_d = rn_q;
    trial = {r_q, q_q[31]} - {1'b0, d_q};
    if (req_i.start) begin
      q_d = ua;
      r_d = '0;
      d_d = ub;
      cnt_d = 6'd32;
      busy_d = 1'b1;
      qn_d = req_i.dividend[31] ^ req_i.divisor[31];
      rn_d = req_i.dividend[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[30:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
    qn_q <= qn_d;
    rn_q <= rn_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = qn_q ? 32'(-q_q) : q_q;
  assign rsp_o.rem = rn_q ? 32'(-r_q) : r_q;
endmodule
`default_nettype wire

/* design/stack_machine_execute_unit_top.sv */
`default_nettype none
// A request goes through S_RD1 and S_RD2 (the top two entries are read) and S_EXEC to
// S_DONE, which raises the result strobe; a pick adds S_PRRD and S_PRWR, a roll S_RLRD,
// S_RLMV (one memory move per cycle) and S_RLLAST, and divmod S_DIVW (one quotient bit
// per cycle in the divider) and S_DIVWR. One request at a time; busy stays high until the
// strobe. Reset clears stack count and control and sets the line number to 1; stack
// memory is not cleared, since only entries below the count are used.
module stack_machine_execute_unit_top #(
  parameter int STACK_DEPTH = 4096,
  parameter int LINE_COUNT = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [4:0]        func_i,
  input  wire logic signed [31:0] immediate_i,
  input  wire logic signed [8:0] input_value_i,
  output logic                   done_o,
  output logic                   out_valid_o,
  output logic [7:0]             out_char_o,
  output logic                   branch_taken_o,
  output logic [15:0]            branch_line_o,
  output logic                   halt_o,
  output logic [2:0]             status_o
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIVW, S_DIVWR, S_PRRD, S_PRWR,
    S_RLRD, S_RLMV, S_RLLAST, S_DONE
  } state_e;

  state_e state_q;
  logic [4:0]  func_q;
  logic [31:0] imm_q;
  logic [8:0]  ival_q;
  logic [CW-1:0] cnt_q;
  logic [15:0] line_q;
  logic [31:0] top_q, nxt_q, moved_q;
  logic [CW-1:0] dep_q, idx_q;
  logic [CW-1:0] nb_q;  // stack count during a pick or roll
  logic        ov_q, bt_q, halt_q, done_q;
  logic [7:0]  oc_q;
  logic [15:0] bl_q;
  logic [2:0]  st_q;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  smeu_pkg::div_req_t dreq;
  smeu_pkg::div_rsp_t drsp;

  smeu_ram #(.Width(32), .Depth(STACK_DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  smeu_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // Helper values.
  logic [CW-1:0] tidx, sidx;
  logic [CW-1:0] roll_first;
  logic signed [33:0] rel_tgt;
  logic [31:0] hword;
  logic [32:0] habs;
  logic        hpos;
  logic [16:0] ln1;
  logic        div_q_we;

  assign tidx = cnt_q - CW'(1);
  assign sidx = cnt_q - CW'(2);
  // Index of the entry that a roll lifts to the top.
  assign roll_first = nb_q - dep_q - CW'(1);
  assign ln1 = {1'b0, line_q} + 17'd1;
  assign rel_tgt = 34'(signed'({1'b0, ln1})) - 34'(signed'(imm_q));
  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;

  // The divider quotient is written during the wait, at the second entry.
  assign div_q_we = (state_q == S_DIVW) && drsp.done;

  function automatic logic bad_line(input logic signed [33:0] a);
    return (a < 0) || (a >= 34'(LINE_COUNT));
  endfunction

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    dreq = '0;
    unique case (state_q)
      S_IDLE: raddr = tidx[AW-1:0];
      S_RD1: raddr = sidx[AW-1:0];
      S_PRRD, S_RLRD: raddr = idx_q[AW-1:0];
      S_RLMV: raddr = AW'(idx_q + CW'(1));
      default: ;
    endcase
    if (state_q == S_RLMV) begin
      // Each entry above the lifted one sinks by one place.
      we = (idx_q != roll_first);
      waddr = AW'(idx_q - CW'(1));
      wdata = rdata;
    end else if (state_q == S_RLLAST) begin
      we = 1'b1;
      waddr = AW'(nb_q - CW'(1));
      wdata = moved_q;
    end else if (state_q == S_PRWR) begin
      we = 1'b1;
      waddr = nb_q[AW-1:0];
      wdata = rdata;
    end else if (div_q_we) begin
      we = 1'b1;
      waddr = sidx[AW-1:0];
      wdata = drsp.quot;
    end else if (state_q == S_DIVWR) begin
      we = 1'b1;
      waddr = tidx[AW-1:0];
      wdata = drsp.rem;
    end else if (state_q == S_EXEC) begin
      unique case (func_q)
        smeu_pkg::F_SUB: if (cnt_q >= CW'(2)) begin
          we = 1'b1; waddr = sidx[AW-1:0]; wdata = nxt_q - top_q;
        end
        smeu_pkg::F_PUSHLN: if (cnt_q < CW'(STACK_DEPTH)) begin
          we = 1'b1; waddr = cnt_q[AW-1:0]; wdata = 32'(ln1);
        end
        smeu_pkg::F_IN: if (cnt_q < CW'(STACK_DEPTH)) begin
          we = 1'b1; waddr = cnt_q[AW-1:0]; wdata = 32'(signed'(ival_q));
        end
        smeu_pkg::F_PUSH: if (cnt_q < CW'(STACK_DEPTH)) begin
          we = 1'b1; waddr = cnt_q[AW-1:0]; wdata = imm_q;
        end
        smeu_pkg::F_DUP: if (cnt_q != '0 && cnt_q < CW'(STACK_DEPTH)) begin
          we = 1'b1; waddr = cnt_q[AW-1:0]; wdata = top_q;
        end
        smeu_pkg::F_ADDLN: if (cnt_q != '0) begin
          we = 1'b1; waddr = tidx[AW-1:0]; wdata = top_q + 32'(ln1);
        end
        smeu_pkg::F_SUBI: if (cnt_q != '0) begin
          we = 1'b1; waddr = tidx[AW-1:0]; wdata = top_q - imm_q;
        end
        default: ;
      endcase
      if (func_q == smeu_pkg::F_DIVMOD && cnt_q >= CW'(2) && top_q != '0) begin
        dreq.start = 1'b1;
        dreq.dividend = nxt_q;
        dreq.divisor = top_q;
      end
    end
  end

  // Depth operand of pick or roll.
  always_comb begin
    hword = (func_q == smeu_pkg::F_ROLLI) ? imm_q : top_q;
    habs = hword[31] ? 33'(-{1'b1, hword}) : {1'b0, hword};
    hpos = !hword[31] && (hword != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      line_q <= 16'd1;
      done_q <= 1'b0;
      ov_q <= 1'b0;
      oc_q <= '0;
      bt_q <= 1'b0;
      bl_q <= '0;
      halt_q <= 1'b0;
      st_q <= smeu_pkg::ST_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          func_q <= func_i;
          imm_q <= immediate_i;
          ival_q <= input_value_i;
          ov_q <= 1'b0; oc_q <= '0; bt_q <= 1'b0; bl_q <= '0;
          halt_q <= 1'b0; st_q <= smeu_pkg::ST_OK;
          state_q <= S_RD1;
        end
        S_RD1: begin
          top_q <= rdata;
          state_q <= S_RD2;
        end
        S_RD2: begin
          nxt_q <= rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_DONE;
          unique case (func_q)
            smeu_pkg::F_DIVMOD:
              if (cnt_q < CW'(2)) st_q <= smeu_pkg::ST_UNDER;
              else if (top_q == '0) st_q <= smeu_pkg::ST_DIVZERO;
              else state_q <= S_DIVW;
            smeu_pkg::F_JUMP:
              if (cnt_q < CW'(2)) st_q <= smeu_pkg::ST_UNDER;
              else if (nxt_q != '0 && bad_line(34'(signed'(top_q))))
                st_q <= smeu_pkg::ST_BADLINE;
              else begin
                cnt_q <= sidx;
                if (nxt_q != '0) begin
                  bt_q <= 1'b1; bl_q <= top_q[15:0]; line_q <= top_q[15:0];
                  halt_q <= (top_q == '0);
                end
              end
            smeu_pkg::F_PUSHLN, smeu_pkg::F_IN, smeu_pkg::F_PUSH:
              if (cnt_q >= CW'(STACK_DEPTH)) st_q <= smeu_pkg::ST_OVER;
              else cnt_q <= cnt_q + CW'(1);
            smeu_pkg::F_SUB:
              if (cnt_q < CW'(2)) st_q <= smeu_pkg::ST_UNDER;
              else cnt_q <= tidx;
            smeu_pkg::F_OUT:
              if (cnt_q == '0) st_q <= smeu_pkg::ST_UNDER;
              else begin
                cnt_q <= tidx; ov_q <= 1'b1; oc_q <= top_q[7:0];
              end
            smeu_pkg::F_ROLL, smeu_pkg::F_ROLLI: begin
              if (func_q == smeu_pkg::F_ROLL && cnt_q == '0)
                st_q <= smeu_pkg::ST_UNDER;
              else if (habs >= 33'((func_q == smeu_pkg::F_ROLL) ? tidx : cnt_q))
                st_q <= smeu_pkg::ST_DEPTH;
              else if (!hpos && (func_q == smeu_pkg::F_ROLLI)
                       && cnt_q >= CW'(STACK_DEPTH))
                st_q <= smeu_pkg::ST_OVER;
              else begin
                nb_q <= (func_q == smeu_pkg::F_ROLL) ? tidx : cnt_q;
                dep_q <= CW'(habs);
                idx_q <= ((func_q == smeu_pkg::F_ROLL) ? tidx : cnt_q)
                         - CW'(1) - CW'(habs);
                if (hpos) begin
                  state_q <= S_RLRD;
                  cnt_q <= tidx + ((func_q == smeu_pkg::F_ROLL) ? CW'(0) : CW'(1));
                end else begin
                  state_q <= S_PRRD;
                end
              end
            end
            smeu_pkg::F_NEWLINE: line_q <= line_q + 16'd1;
            smeu_pkg::F_CBREL, smeu_pkg::F_CBABS, smeu_pkg::F_CMPSKIP: begin
              logic signed [33:0] t;
              logic c;
              t = (func_q == smeu_pkg::F_CBREL) ? rel_tgt :
                  (func_q == smeu_pkg::F_CBABS) ? 34'(signed'(imm_q)) :
                  34'(signed'({1'b0, ln1}));
              c = (func_q == smeu_pkg::F_CMPSKIP) ? (top_q != imm_q) : (top_q != '0);
              if (cnt_q == '0) st_q <= smeu_pkg::ST_UNDER;
              else if (c && bad_line(t)) st_q <= smeu_pkg::ST_BADLINE;
              else begin
                cnt_q <= tidx;
                if (c) begin
                  bt_q <= 1'b1; bl_q <= t[15:0]; line_q <= t[15:0];
                  halt_q <= (t == 0);
                end
              end
            end
            smeu_pkg::F_ADDLN, smeu_pkg::F_SUBI:
              if (cnt_q == '0) st_q <= smeu_pkg::ST_UNDER;
            smeu_pkg::F_BREL:
              if (bad_line(rel_tgt)) st_q <= smeu_pkg::ST_BADLINE;
              else begin
                bt_q <= 1'b1; bl_q <= rel_tgt[15:0]; line_q <= rel_tgt[15:0];
                halt_q <= (rel_tgt == 0);
              end
            smeu_pkg::F_DUP:
              if (cnt_q == '0) st_q <= smeu_pkg::ST_UNDER;
              else if (cnt_q >= CW'(STACK_DEPTH)) st_q <= smeu_pkg::ST_OVER;
              else cnt_q <= cnt_q + CW'(1);
            smeu_pkg::F_DROP:
              if (cnt_q == '0) st_q <= smeu_pkg::ST_UNDER;
              else cnt_q <= tidx;
            default: ;
          endcase
        end
        S_DIVW: if (drsp.done) state_q <= S_DIVWR;
        S_DIVWR: state_q <= S_DONE;
        S_PRRD: state_q <= S_PRWR;
        S_PRWR: begin
          // A pick under F_ROLL leaves the popped depth word overwritten by the copy.
          cnt_q <= nb_q + CW'(1);
          state_q <= S_DONE;
        end
        S_RLRD: state_q <= S_RLMV;
        S_RLMV: begin
          if (idx_q == roll_first) moved_q <= rdata;
          idx_q <= idx_q + CW'(1);
          state_q <= (idx_q + CW'(1) >= nb_q) ? S_RLLAST : S_RLMV;
        end
        S_RLLAST: state_q <= S_DONE;
        S_DONE: begin
          done_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = done_q & ov_q;
  assign out_char_o = done_q ? oc_q : '0;
  assign branch_taken_o = done_q & bt_q;
  assign branch_line_o = done_q ? bl_q : '0;
  assign halt_o = done_q & halt_q;
  assign status_o = done_q ? st_q : smeu_pkg::ST_OK;
endmodule
`default_nettype wire

/* design/smeu_checker.sv */
`default_nettype none
`include "stack_machine_execute_unit_top_assert.svh"
module smeu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_i,
  input wire logic       done_i,
  input wire logic       out_valid_i,
  input wire logic       branch_taken_i,
  input wire logic       halt_i,
  input wire logic [2:0] status_i
);
  `SMEU_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_i, busy_i, "no busy")
  `SMEU_ASSERT_IMP(a_halt_br, clk_i, rst_ni, halt_i, branch_taken_i && done_i, "bad halt")
  `SMEU_ASSERT_IMP(a_err_quiet, clk_i, rst_ni, status_i != smeu_pkg::ST_OK, !out_valid_i && !branch_taken_i, "flags")
  `SMEU_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_i, !busy_i, "busy with result")
endmodule

bind stack_machine_execute_unit_top smeu_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .done_i(done_o),
  .out_valid_i(out_valid_o), .branch_taken_i(branch_taken_o), .halt_i(halt_o),
  .status_i(status_o)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
// Self-checking bench for the stack machine execute unit.
// A queue of pending requests is filled up front by an initial block. A
// clocked driver issues them on the start/busy handshake, and as each
// request is accepted it runs the instruction through a behavioral copy of
// the machine. The copy holds its own stack, depth and line number, and it
// queues the result that the unit should report. A clocked monitor compares
// each result strobe, field by field, with the oldest queued result.
module tb;
  localparam int DEPTH = 4096;
  localparam int LINES = 65536;
  localparam int RANDOM_COUNT = 1550;

  // One decoded instruction. When hold is set, the driver first waits until
  // every queued result has come back.
  typedef struct {
    logic [4:0]  f;
    logic [31:0] imm;
    logic [8:0]  ival;
    bit          hold;
  } instr_t;

  typedef struct packed {
    logic        ov;
    logic [7:0]  oc;
    logic        bt;
    logic [15:0] bl;
    logic        hl;
    logic [2:0]  st;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [4:0] func_i = '0;
  logic signed [31:0] immediate_i = '0;
  logic signed [8:0] input_value_i = '0;
  logic busy, done_o, out_valid_o, branch_taken_o, halt_o;
  logic [7:0] out_char_o;
  logic [15:0] branch_line_o;
  logic [2:0] status_o;

  stack_machine_execute_unit_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .func_i(func_i), .immediate_i(immediate_i), .input_value_i(input_value_i),
    .done_o(done_o), .out_valid_o(out_valid_o), .out_char_o(out_char_o),
    .branch_taken_o(branch_taken_o), .branch_line_o(branch_line_o),
    .halt_o(halt_o), .status_o(status_o)
  );

  always #4 clk_i = ~clk_i;

  instr_t   pending_q[$];
  outcome_t outcome_q[$];

  // Shadow state of the machine.
  logic [31:0] shadow_stack[DEPTH];
  int          shadow_count = 0;
  longint      shadow_line = 1;

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_faults = 0;
  int n_branches = 0;

  function automatic bit bad_target(longint a);
    return a < 0 || a >= LINES;
  endfunction

  // Pick (depth h <= 0) or roll (h > 0) on the shadow stack.
  function automatic logic [2:0] pick_or_roll(longint h);
    longint d;
    int i;
    logic [31:0] v;
    d = (h < 0) ? -h : h;
    if (d >= shadow_count) return smeu_pkg::ST_DEPTH;
    if (h <= 0) begin
      if (shadow_count >= DEPTH) return smeu_pkg::ST_OVER;
      shadow_stack[shadow_count] = shadow_stack[shadow_count - 1 - d];
      shadow_count++;
    end else begin
      i = shadow_count - 1 - int'(d);
      v = shadow_stack[i];
      for (int k = i; k < shadow_count - 1; k++) shadow_stack[k] = shadow_stack[k + 1];
      shadow_stack[shadow_count - 1] = v;
    end
    return smeu_pkg::ST_OK;
  endfunction

  // Executes one instruction on the shadow machine and queues its result.
  task automatic execute_instr(logic [4:0] f, logic signed [31:0] imm,
                               logic signed [8:0] iv);
    int n;
    longint x, y, tgt;
    bit cond;
    logic [2:0] st;
    outcome_t o;
    n = shadow_count;
    st = smeu_pkg::ST_OK;
    cond = 0;
    tgt = 0;
    o = '0;
    case (f)
      smeu_pkg::F_DIVMOD: begin
        if (n < 2) st = smeu_pkg::ST_UNDER;
        else begin
          x = $signed(shadow_stack[n - 1]);
          y = $signed(shadow_stack[n - 2]);
          if (x == 0) st = smeu_pkg::ST_DIVZERO;
          else begin
            shadow_stack[n - 2] = 32'(y / x);
            shadow_stack[n - 1] = 32'(y % x);
          end
        end
      end
      smeu_pkg::F_JUMP: begin
        if (n < 2) st = smeu_pkg::ST_UNDER;
        else begin
          tgt = $signed(shadow_stack[n - 1]);
          cond = shadow_stack[n - 2] != 0;
          if (cond && bad_target(tgt)) st = smeu_pkg::ST_BADLINE;
          else shadow_count = n - 2;
        end
      end
      smeu_pkg::F_PUSHLN, smeu_pkg::F_IN, smeu_pkg::F_PUSH: begin
        if (n >= DEPTH) st = smeu_pkg::ST_OVER;
        else begin
          shadow_stack[n] = (f == smeu_pkg::F_PUSHLN) ? 32'(shadow_line + 1) :
                            (f == smeu_pkg::F_IN) ? 32'(longint'(iv)) : imm;
          shadow_count = n + 1;
        end
      end
      smeu_pkg::F_SUB: begin
        if (n < 2) st = smeu_pkg::ST_UNDER;
        else begin
          shadow_stack[n - 2] = shadow_stack[n - 2] - shadow_stack[n - 1];
          shadow_count = n - 1;
        end
      end
      smeu_pkg::F_OUT: begin
        if (n < 1) st = smeu_pkg::ST_UNDER;
        else begin
          o.oc = shadow_stack[n - 1][7:0];
          o.ov = 1'b1;
          shadow_count = n - 1;
        end
      end
      smeu_pkg::F_ROLL: begin
        if (n < 1) st = smeu_pkg::ST_UNDER;
        else begin
          x = $signed(shadow_stack[n - 1]);
          shadow_count = n - 1;
          st = pick_or_roll(x);
          if (st != smeu_pkg::ST_OK) shadow_count = n;
        end
      end
      smeu_pkg::F_NEWLINE: shadow_line = (shadow_line + 1) & 16'hFFFF;
      smeu_pkg::F_CBREL, smeu_pkg::F_CBABS, smeu_pkg::F_CMPSKIP: begin
        if (n < 1) st = smeu_pkg::ST_UNDER;
        else begin
          if (f == smeu_pkg::F_CBREL) tgt = shadow_line + 1 - longint'(imm);
          else if (f == smeu_pkg::F_CBABS) tgt = imm;
          else tgt = shadow_line + 1;
          cond = (f == smeu_pkg::F_CMPSKIP) ? (shadow_stack[n - 1] - imm) != 0
                                            : shadow_stack[n - 1] != 0;
          if (cond && bad_target(tgt)) st = smeu_pkg::ST_BADLINE;
          else shadow_count = n - 1;
        end
      end
      smeu_pkg::F_ADDLN, smeu_pkg::F_SUBI: begin
        if (n < 1) st = smeu_pkg::ST_UNDER;
        else if (f == smeu_pkg::F_ADDLN) shadow_stack[n - 1] += 32'(shadow_line + 1);
        else shadow_stack[n - 1] -= imm;
      end
      smeu_pkg::F_BREL: begin
        tgt = shadow_line + 1 - longint'(imm);
        cond = 1;
        if (bad_target(tgt)) st = smeu_pkg::ST_BADLINE;
      end
      smeu_pkg::F_ROLLI: st = pick_or_roll(imm);
      smeu_pkg::F_DUP: begin
        if (n < 1) st = smeu_pkg::ST_UNDER;
        else if (n >= DEPTH) st = smeu_pkg::ST_OVER;
        else begin
          shadow_stack[n] = shadow_stack[n - 1];
          shadow_count = n + 1;
        end
      end
      smeu_pkg::F_DROP: begin
        if (n < 1) st = smeu_pkg::ST_UNDER;
        else shadow_count = n - 1;
      end
      default: ;
    endcase
    // A faulting instruction leaves every piece of state untouched and
    // reports nothing but its status.
    if (st != smeu_pkg::ST_OK) begin
      o.ov = 1'b0;
      o.oc = '0;
      cond = 0;
      n_faults++;
    end
    if (cond) begin
      o.bt = 1'b1;
      o.bl = tgt[15:0];
      o.hl = (tgt == 0);
      shadow_line = tgt & 16'hFFFF;
      n_branches++;
    end
    o.st = st;
    outcome_q.push_back(o);
  endtask

  // Driver. The request on the ports is taken at an edge where start is
  // high and busy is low; a new one is chosen only after that, so start
  // gets at most one assignment per edge.
  int idle_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        execute_instr(func_i, immediate_i, input_value_i);
        n_requests++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_q.size() == 0) begin
          start <= 1'b0;
        end else if (pending_q[0].hold && (outcome_q.size() != 0 || start)) begin
          // Hold off until the unit has drained completely.
          start <= 1'b0;
        end else if (pending_q.size() > 150 && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(0, 3);
          start <= 1'b0;
        end else begin
          func_i <= pending_q[0].f;
          immediate_i <= pending_q[0].imm;
          input_value_i <= pending_q[0].ival;
          start <= 1'b1;
          void'(pending_q.pop_front());
        end
      end
    end
  end

  // Monitor. Each strobe is one result and is checked against the oldest
  // queued result.
  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (outcome_q.size() == 0) begin
        $display("%0t: result strobe with none outstanding, expected none, actual status %0d",
                 $time, status_o);
        errors++;
      end else begin
        e = outcome_q.pop_front();
        check_field("out_valid", 16'(e.ov), 16'(out_valid_o));
        check_field("out_char", 16'(e.oc), 16'(out_char_o));
        check_field("branch_taken", 16'(e.bt), 16'(branch_taken_o));
        check_field("branch_line", e.bl, branch_line_o);
        check_field("halt", 16'(e.hl), 16'(halt_o));
        check_field("status", 16'(e.st), 16'(status_o));
      end
    end
  end

  // Stimulus helpers. depth_guess tracks the nominal stack depth that the
  // generated program should have, so that most random code is well formed.
  int depth_guess = 0;
  int made = 0;

  task automatic add(logic [4:0] f, logic [31:0] imm = '0, logic [8:0] iv = '0,
                     bit hold = 0);
    instr_t it;
    it.f = f;
    it.imm = imm;
    it.ival = iv;
    it.hold = hold;
    pending_q.push_back(it);
    if (f <= smeu_pkg::F_DROP) made++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  task automatic add_random_block();
    int r, h;
    r = $urandom_range(0, 99);
    if (depth_guess > 40) begin
      repeat (10) add(smeu_pkg::F_DROP);
      depth_guess -= 10;
    end else if (r < 8) begin
      // Noise: any code, any operands.
      add(5'($urandom_range(0, 31)), $urandom, 9'($urandom));
    end else if (depth_guess < 3 || r < 20) begin
      case ($urandom_range(0, 2))
        0: add(smeu_pkg::F_PUSH, rand_word());
        1: add(smeu_pkg::F_IN, '0,
               ($urandom_range(0, 9) == 0) ? 9'h1FF : 9'($urandom_range(0, 255)));
        default: add(smeu_pkg::F_PUSHLN);
      endcase
      depth_guess++;
    end else if (r < 32) begin
      add(smeu_pkg::F_PUSH, rand_word());
      add(smeu_pkg::F_PUSH, ($urandom_range(0, 7) == 0) ? 32'd0 : rand_word());
      add(($urandom_range(0, 1) != 0) ? smeu_pkg::F_DIVMOD : smeu_pkg::F_SUB);
      depth_guess += 1;
    end else if (r < 42) begin
      add(smeu_pkg::F_PUSH, $urandom_range(0, 3) != 0 ? 32'd1 : 32'($urandom_range(0, 1)));
      add(smeu_pkg::F_PUSH, ($urandom_range(0, 9) == 0) ? rand_word() :
          32'($urandom_range(0, LINES - 1)));
      add(smeu_pkg::F_JUMP);
    end else if (r < 52) begin
      add(smeu_pkg::F_PUSH, 32'($urandom_range(0, 2)));
      case ($urandom_range(0, 3))
        0: add(smeu_pkg::F_CBREL, 32'($signed($urandom_range(0, 400)) - 200));
        1: add(smeu_pkg::F_CBABS, ($urandom_range(0, 9) == 0) ? rand_word() :
               32'($urandom_range(0, LINES - 1)));
        2: add(smeu_pkg::F_CMPSKIP, 32'($urandom_range(0, 2)));
        default: add(smeu_pkg::F_BREL, 32'($signed($urandom_range(0, 400)) - 200));
      endcase
    end else if (r < 70) begin
      // Pick or roll at a depth mostly inside the stack.
      h = $urandom_range(0, depth_guess) * (($urandom_range(0, 1) != 0) ? 1 : -1);
      if ($urandom_range(0, 1) != 0) begin
        add(smeu_pkg::F_PUSH, 32'(h));
        add(smeu_pkg::F_ROLL);
      end else begin
        add(smeu_pkg::F_ROLLI, 32'(h));
      end
      if (h <= 0) depth_guess++;
    end else begin
      case ($urandom_range(0, 6))
        0: begin add(smeu_pkg::F_OUT); depth_guess--; end
        1: begin add(smeu_pkg::F_DROP); depth_guess--; end
        2: begin add(smeu_pkg::F_DUP); depth_guess++; end
        3: add(smeu_pkg::F_ADDLN);
        4: add(smeu_pkg::F_SUBI, rand_word());
        5: add(smeu_pkg::F_NEWLINE);
        default: add(smeu_pkg::F_OUT);
      endcase
    end
    if (depth_guess < 0) depth_guess = 0;
  endtask

  initial begin
    // Directed part: every fault on an empty stack, divide edge cases,
    // depth and target limits, halt and line wrap.
    add(smeu_pkg::F_DIVMOD); add(smeu_pkg::F_JUMP); add(smeu_pkg::F_SUB);
    add(smeu_pkg::F_OUT); add(smeu_pkg::F_ROLL); add(smeu_pkg::F_CBREL);
    add(smeu_pkg::F_CMPSKIP); add(smeu_pkg::F_ADDLN); add(smeu_pkg::F_SUBI);
    add(smeu_pkg::F_DUP); add(smeu_pkg::F_DROP); add(smeu_pkg::F_CBABS);
    add(smeu_pkg::F_PUSH, 32'h8000_0000); add(smeu_pkg::F_PUSH, 32'hFFFF_FFFF);
    add(smeu_pkg::F_DIVMOD);
    add(smeu_pkg::F_PUSH, 32'd0); add(smeu_pkg::F_DIVMOD);
    add(smeu_pkg::F_ROLLI, 32'h8000_0000);
    add(smeu_pkg::F_BREL, 32'd5);
    add(smeu_pkg::F_PUSH, 32'd1); add(smeu_pkg::F_PUSH, 32'd65536); add(smeu_pkg::F_JUMP);
    add(smeu_pkg::F_PUSH, 32'd0); add(smeu_pkg::F_JUMP);
    add(smeu_pkg::F_CBABS, 32'd65535); add(smeu_pkg::F_NEWLINE);
    add(smeu_pkg::F_IN, '0, 9'h1FF); add(smeu_pkg::F_IN, '0, 9'd255);
    add(5'd18, $urandom); add(5'd31, $urandom);
    // Let the unit drain, then empty the stack before the random part.
    add(smeu_pkg::F_NEWLINE, '0, '0, 1);
    repeat (12) add(smeu_pkg::F_DROP);
    made = 0;
    depth_guess = 0;
    while (made < RANDOM_COUNT) begin
      add_random_block();
      // Now and then let the unit drain before carrying on.
      if ($urandom_range(0, 299) == 0) add(smeu_pkg::F_NEWLINE, '0, '0, 1);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start || outcome_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (outcome_q.size() != 0) errors++;

    $display("Ran %0d requests, %0d results seen; %0d faults and %0d taken branches.",
             n_requests, n_results, n_faults, n_branches);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+design
design/smeu_pkg.sv
design/smeu_ram.sv
design/smeu_div.sv
design/stack_machine_execute_unit_top.sv
design/smeu_checker.sv
verif/tb.sv
